// ----- rtl/core/blpm_pkg.sv -----
// Shared types and constants for the binary trie longest prefix match block.
// Depends on nothing; used by blpm_node_store, the top level and the bench.
package blpm_pkg;

   localparam int NODE_COUNT   = 1024;
   localparam int NODE_BITS    = $clog2(NODE_COUNT);
   localparam int USED_BITS    = NODE_BITS + 1;
   localparam int ADDRESS_BITS = 32;
   localparam int DEPTH_BITS   = $clog2(ADDRESS_BITS + 1);
   localparam int HOP_BITS     = 32;

   // Operation codes of the func field
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // Result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                    func;
      logic [ADDRESS_BITS-1:0] address;
      logic [5:0]              prefix_len;
      logic [HOP_BITS-1:0]     hop_in;
   } req_type;

   typedef struct packed {
      logic [HOP_BITS-1:0] hop_out;
      logic                found;
      logic                status;
   } rsp_type;

   // One trie node as read back from the store
   typedef struct packed {
      logic [NODE_BITS-1:0] child_zero;
      logic [NODE_BITS-1:0] child_one;
      logic [HOP_BITS-1:0]  hop;
   } node_type;

   // Write command to the node store: one address, per-field enables
   typedef struct packed {
      logic                 en_zero;
      logic                 en_one;
      logic                 en_hop;
      logic [NODE_BITS-1:0] addr;
      logic [NODE_BITS-1:0] child;
      logic [HOP_BITS-1:0]  hop;
   } node_wr_type;

endpackage

// ----- rtl/core/blpm_node_store.sv -----
// Trie node store: child and next hop memories plus the root node in flops.
// Depends on blpm_pkg for node_type and node_wr_type.
module blpm_node_store import blpm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [NODE_BITS-1:0] rd_addr,
   output node_type             rd_data,
   input  node_wr_type          wr
);

   logic [NODE_BITS-1:0] zero_mem [NODE_COUNT];
   logic [NODE_BITS-1:0] one_mem  [NODE_COUNT];
   logic [HOP_BITS-1:0]  hop_mem  [NODE_COUNT];

   node_type root_ff;
   node_type mem_data_ff;
   logic     rd_root_ff;

   // Hold the root in flops so reset clears it at once
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff    <= '0;
         rd_root_ff <= 1'b1;
      end else begin
         rd_root_ff <= (rd_addr == '0);
         if (wr.addr == '0) begin
            if (wr.en_zero) root_ff.child_zero <= wr.child;
            if (wr.en_one)  root_ff.child_one  <= wr.child;
            if (wr.en_hop)  root_ff.hop        <= wr.hop;
         end
      end
   end

   // Write every node into the memories; register the read data
   always_ff @(posedge clock) begin
      if (wr.en_zero) zero_mem[wr.addr] <= wr.child;
      if (wr.en_one)  one_mem[wr.addr]  <= wr.child;
      if (wr.en_hop)  hop_mem[wr.addr]  <= wr.hop;
      mem_data_ff.child_zero <= zero_mem[rd_addr];
      mem_data_ff.child_one  <= one_mem[rd_addr];
      mem_data_ff.hop        <= hop_mem[rd_addr];
   end

   assign rd_data = rd_root_ff ? root_ff : mem_data_ff;

endmodule

// ----- rtl/core/binary_trie_longest_prefix_match_top.sv -----
// Top level of the binary trie longest prefix match route table.
// Depends on blpm_pkg and blpm_node_store.
//
// Usage:
//   A request word (insert or lookup) is taken when start is high and busy is
//   low. Its single response word appears on rsp_word for one cycle, marked by
//   rsp_strobe; the receiver cannot stall and must take it then.
//   The walk advances one trie level per cycle: the registered read of the
//   node store feeds the child pointer straight back as the next read address.
//   Lookup: busy while it visits the levels (up to 33 including the root); the
//   response is strobed in the cycle busy drops.
//   Insert: busy while it walks the existing levels and a final check, then an
//   allocate state (clear) and a link state per new node and a finish state
//   that writes the next hop, then the strobe; if the new nodes do not fit, the check strobes a full status instead.
//   A new request is accepted in the cycle the previous response is strobed.
//   Reset clears the root node and sets the used count to one. Other nodes are
//   cleared when allocated and only allocated nodes are ever read, so no
//   clearing pass is needed and the block is ready right after reset.
module binary_trie_longest_prefix_match_top import blpm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_word,
   output logic    rsp_strobe,
   output rsp_type rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_ALLOC,
      ST_LINK,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic                    func_ff, func_in;
   logic [ADDRESS_BITS-1:0] addr_ff, addr_in;
   logic [DEPTH_BITS-1:0]   plen_ff, plen_in;
   logic [DEPTH_BITS-1:0]   depth_ff, depth_in;
   logic [HOP_BITS-1:0]     hop_ff, hop_in;
   logic [HOP_BITS-1:0]     best_ff, best_in;
   logic [NODE_BITS-1:0]    cur_ff, cur_in;
   logic [USED_BITS-1:0]    used_ff, used_in;
   logic                    strobe_ff, strobe_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [NODE_BITS-1:0]    rd_addr;
   node_type                node;
   node_wr_type             wr;
   logic                    cur_bit;
   logic [NODE_BITS-1:0]    nxt;
   logic [HOP_BITS-1:0]     seen_hop;
   logic [DEPTH_BITS-1:0]   missing;
   logic [USED_BITS-1:0]    free_nodes;
   logic [DEPTH_BITS-1:0]   req_plen;

   blpm_node_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (node),
      .wr      (wr)
   );

   // Current bit is the top of the shifted address
   assign cur_bit    = addr_ff[ADDRESS_BITS-1];
   assign nxt        = cur_bit ? node.child_one : node.child_zero;
   assign seen_hop   = (node.hop != '0) ? node.hop : best_ff;
   assign missing    = plen_ff - depth_ff;
   assign free_nodes = USED_BITS'(NODE_COUNT) - used_ff;
   assign req_plen   = (req_word.prefix_len > 6'(ADDRESS_BITS)) ?
                       DEPTH_BITS'(ADDRESS_BITS) : DEPTH_BITS'(req_word.prefix_len);

   // Sequence one walk step, allocation or write per cycle
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      addr_in   = addr_ff;
      plen_in   = plen_ff;
      depth_in  = depth_ff;
      hop_in    = hop_ff;
      best_in   = best_ff;
      cur_in    = cur_ff;
      used_in   = used_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      rd_addr   = '0;
      wr        = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in  = req_word.func;
               addr_in  = req_word.address;
               plen_in  = req_plen;
               hop_in   = req_word.hop_in;
               depth_in = '0;
               cur_in   = '0;
               best_in  = '0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (func_ff == FUNC_LOOKUP) begin
               best_in = seen_hop;
               if (depth_ff == DEPTH_BITS'(ADDRESS_BITS) || nxt == '0) begin
                  strobe_in      = 1'b1;
                  rsp_in.hop_out = seen_hop;
                  rsp_in.found   = (seen_hop != '0);
                  rsp_in.status  = STATUS_OK;
                  state_in       = ST_IDLE;
               end else begin
                  rd_addr  = nxt;
                  cur_in   = nxt;
                  depth_in = depth_ff + 1'b1;
                  addr_in  = addr_ff << 1;
               end
            end else begin
               if (depth_ff == plen_ff) begin
                  state_in = ST_FINISH;
               end else if (nxt != '0) begin
                  rd_addr  = nxt;
                  cur_in   = nxt;
                  depth_in = depth_ff + 1'b1;
                  addr_in  = addr_ff << 1;
               end else if (used_ff > USED_BITS'(NODE_COUNT) ||
                            USED_BITS'(missing) > free_nodes) begin
                  strobe_in      = 1'b1;
                  rsp_in.hop_out = '0;
                  rsp_in.found   = 1'b0;
                  rsp_in.status  = STATUS_FULL;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_ALLOC;
               end
            end
         end
         ST_ALLOC: begin
            // Clear the fresh node in all three fields
            wr.en_zero = 1'b1;
            wr.en_one  = 1'b1;
            wr.en_hop  = 1'b1;
            wr.addr    = used_ff[NODE_BITS-1:0];
            state_in   = ST_LINK;
         end
         ST_LINK: begin
            // Point the parent at the fresh node and step down
            wr.en_zero = !cur_bit;
            wr.en_one  = cur_bit;
            wr.addr    = cur_ff;
            wr.child   = used_ff[NODE_BITS-1:0];
            cur_in     = used_ff[NODE_BITS-1:0];
            used_in    = used_ff + 1'b1;
            depth_in   = depth_ff + 1'b1;
            addr_in    = addr_ff << 1;
            state_in   = ((depth_ff + 1'b1) == plen_ff) ? ST_FINISH : ST_ALLOC;
         end
         ST_FINISH: begin
            wr.en_hop      = 1'b1;
            wr.addr        = cur_ff;
            wr.hop         = hop_ff;
            strobe_in      = 1'b1;
            rsp_in.hop_out = '0;
            rsp_in.found   = 1'b0;
            rsp_in.status  = STATUS_OK;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and registered response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         used_ff   <= USED_BITS'(1);
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         strobe_ff <= strobe_in;
      end
      func_ff  <= func_in;
      addr_ff  <= addr_in;
      plen_ff  <= plen_in;
      depth_ff <= depth_in;
      hop_ff   <= hop_in;
      best_ff  <= best_in;
      cur_ff   <= cur_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the binary trie longest prefix match route table.
// Depends on blpm_pkg and binary_trie_longest_prefix_match_top; keeps its own
// trie to predict every response word and checks it at the response strobe.
module tb;
   import blpm_pkg::*;

   localparam int RANDOM_WORDS = 1900;
   localparam int PHASE_WORDS  = RANDOM_WORDS / 4;
   localparam int BASE_COUNT   = 6;
   localparam int TAIL_CYCLES  = 80;

   // Percent of cycles the request side holds start low, per phase
   localparam int unsigned IDLE_PCT [4] = '{0, 54, 0, 16};

   typedef struct {
      req_type     word;
      int unsigned idle_pct;
   } request_type;

   typedef struct {
      logic [ADDRESS_BITS-1:0] address;
      logic [5:0]              prefix_len;
   } route_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_word = '0;
   logic    rsp_strobe;
   rsp_type rsp_word;

   request_type route_requests [$];
   route_type   route_list [$];
   rsp_type     predicted_rsp [$];
   int          words_taken = 0;
   int          mismatch_count = 0;

   // Shadow trie
   logic [NODE_BITS-1:0] next_zero [NODE_COUNT] = '{default: '0};
   logic [NODE_BITS-1:0] next_one [NODE_COUNT] = '{default: '0};
   logic [HOP_BITS-1:0]  node_next_hop [NODE_COUNT] = '{default: '0};
   int unsigned          alloc_count = 1;

   binary_trie_longest_prefix_match_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Walk the existing path, then allocate the rest only if it all fits
   function automatic logic trie_insert(logic [ADDRESS_BITS-1:0] addr, logic [5:0] plen_in,
                                        logic [HOP_BITS-1:0] hop);
      int unsigned plen;
      int unsigned depth;
      int unsigned cur;
      int unsigned nxt;
      int unsigned fresh;
      logic        b;
      plen  = (plen_in > ADDRESS_BITS) ? ADDRESS_BITS : plen_in;
      cur   = 0;
      depth = 0;
      while (depth < plen) begin
         b   = addr[ADDRESS_BITS-1-depth];
         nxt = b ? next_one[cur] : next_zero[cur];
         if (nxt == 0) break;
         cur = nxt;
         depth++;
      end
      if (plen - depth > NODE_COUNT - alloc_count) return STATUS_FULL;
      while (depth < plen) begin
         fresh = alloc_count;
         alloc_count++;
         next_zero[fresh]     = '0;
         next_one[fresh]      = '0;
         node_next_hop[fresh] = '0;
         b = addr[ADDRESS_BITS-1-depth];
         if (b) next_one[cur] = fresh[NODE_BITS-1:0];
         else next_zero[cur] = fresh[NODE_BITS-1:0];
         cur = fresh;
         depth++;
      end
      node_next_hop[cur] = hop;
      return STATUS_OK;
   endfunction

   // Deepest non-zero next hop along the address path, root included
   function automatic logic [HOP_BITS-1:0] trie_lookup(logic [ADDRESS_BITS-1:0] addr);
      logic [HOP_BITS-1:0] best;
      int unsigned         cur;
      int unsigned         nxt;
      best = node_next_hop[0];
      cur  = 0;
      for (int depth = 0; depth < ADDRESS_BITS; depth++) begin
         nxt = addr[ADDRESS_BITS-1-depth] ? next_one[cur] : next_zero[cur];
         if (nxt == 0) break;
         cur = nxt;
         if (node_next_hop[cur] != 0) best = node_next_hop[cur];
      end
      return best;
   endfunction

   function automatic rsp_type trie_apply(req_type w);
      rsp_type r;
      r = '0;
      if (w.func == FUNC_INSERT) begin
         r.status = trie_insert(w.address, w.prefix_len, w.hop_in);
      end else begin
         r.hop_out = trie_lookup(w.address);
         r.found   = (r.hop_out != 0);
         r.status  = STATUS_OK;
      end
      return r;
   endfunction

   task automatic add_request(input logic func, input logic [ADDRESS_BITS-1:0] addr,
                              input logic [5:0] plen, input logic [HOP_BITS-1:0] hop,
                              input int unsigned idle);
      request_type q;
      route_type   rt;
      q.word.func       = func;
      q.word.address    = addr;
      q.word.prefix_len = plen;
      q.word.hop_in     = hop;
      q.idle_pct        = idle;
      route_requests.push_back(q);
      if (func == FUNC_INSERT) begin
         rt.address    = addr;
         rt.prefix_len = plen;
         route_list.push_back(rt);
      end
   endtask

   // Request driver: predict on accept, then present the next word or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted_rsp.push_back(trie_apply(req_word));
            void'(route_requests.pop_front());
            words_taken++;
         end
         if (route_requests.size() != 0 &&
             $urandom_range(99) >= route_requests[0].idle_pct) begin
            start    <= 1'b1;
            req_word <= route_requests[0].word;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Response monitor: compare each strobed word with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (predicted_rsp.size() == 0) begin
            $error("response word with none expected: hop_out %h found %b status %b",
                   rsp_word.hop_out, rsp_word.found, rsp_word.status);
            mismatch_count++;
         end else begin
            want = predicted_rsp.pop_front();
            if (rsp_word.hop_out !== want.hop_out) begin
               $error("hop_out mismatch: expected %h, actual %h", want.hop_out, rsp_word.hop_out);
               mismatch_count++;
            end
            if (rsp_word.found !== want.found) begin
               $error("found mismatch: expected %b, actual %b", want.found, rsp_word.found);
               mismatch_count++;
            end
            if (rsp_word.status !== want.status) begin
               $error("status mismatch: expected %b, actual %b", want.status, rsp_word.status);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      logic [ADDRESS_BITS-1:0] bases [BASE_COUNT];
      logic [ADDRESS_BITS-1:0] base;
      logic [ADDRESS_BITS-1:0] near;
      logic [ADDRESS_BITS-1:0] mask;
      logic [HOP_BITS-1:0]     hop;
      route_type               rt;
      int unsigned             idle;
      int unsigned             pick;
      int unsigned             spread;
      int                      total;

      // Directed words: empty table, default route, /32 at both ends,
      // oversized prefix lengths, nested prefixes and route removal
      add_request(FUNC_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 0);
      add_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 0);
      add_request(FUNC_INSERT, 32'h0000_0000, 6'd0, 32'hA5A5_0001, 0);
      add_request(FUNC_LOOKUP, 32'h1234_5678, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 0);
      add_request(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'h0, 0);
      add_request(FUNC_LOOKUP, 32'hFFFF_FFFE, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'h0000_0000, 6'd63, 32'h0000_0001, 0);
      add_request(FUNC_LOOKUP, 32'h0000_0000, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'hC0A8_0000, 6'd16, 32'h0000_0010, 0);
      add_request(FUNC_INSERT, 32'hC0A8_0100, 6'd24, 32'h0000_0020, 0);
      add_request(FUNC_LOOKUP, 32'hC0A8_0105, 6'd0, 32'h0, 0);
      add_request(FUNC_LOOKUP, 32'hC0A8_0205, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'hC0A8_0100, 6'd24, 32'h0000_0000, 0);
      add_request(FUNC_LOOKUP, 32'hC0A8_0105, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'h8000_0000, 6'd1, 32'h0000_0002, 0);
      add_request(FUNC_LOOKUP, 32'h9000_0000, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'h0A00_0000, 6'd33, 32'h0000_0003, 0);
      add_request(FUNC_LOOKUP, 32'h0A00_0000, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'h0000_0000, 6'd0, 32'h0000_0000, 0);
      add_request(FUNC_LOOKUP, 32'h1234_5678, 6'd0, 32'h0, 0);
      add_request(FUNC_INSERT, 32'h5500_0000, 6'd8, 32'h0000_0000, 0);
      add_request(FUNC_LOOKUP, 32'h5500_0001, 6'd0, 32'h0, 0);

      // Random words clustered around a few prefixes so paths share nodes;
      // the scattered inserts eventually exhaust the node store
      foreach (bases[k]) bases[k] = $urandom();
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         idle   = IDLE_PCT[n / PHASE_WORDS];
         pick   = $urandom_range(99);
         base   = bases[$urandom_range(BASE_COUNT-1)];
         spread = ($urandom_range(3) == 0) ? $urandom_range(32) : $urandom_range(12);
         near   = base ^ ($urandom() & (32'hFFFF_FFFF >> (32 - spread)));
         hop    = ($urandom_range(15) == 0) ? 32'h0 : $urandom();
         rt     = route_list[$urandom_range(route_list.size()-1)];
         mask   = 32'hFFFF_FFFF >> rt.prefix_len;
         if (pick < 8) begin
            add_request(FUNC_INSERT, $urandom(), 6'($urandom_range(32)), hop, idle);
         end else if (pick < 18) begin
            add_request(FUNC_INSERT, rt.address, rt.prefix_len, hop, idle);
         end else if (pick < 45) begin
            add_request(FUNC_INSERT, near,
                        6'(($urandom_range(9) == 0) ? $urandom_range(63) :
                                                      $urandom_range(32)),
                        hop, idle);
         end else if (pick < 75) begin
            add_request(FUNC_LOOKUP, (rt.address & ~mask) | ($urandom() & mask),
                        6'($urandom_range(63)), $urandom(), idle);
         end else if (pick < 90) begin
            add_request(FUNC_LOOKUP, near, 6'($urandom_range(63)), $urandom(), idle);
         end else begin
            add_request(FUNC_LOOKUP, $urandom(), 6'($urandom_range(63)), $urandom(), idle);
         end
      end
      total = route_requests.size();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Drain: every word taken and every response seen, then a quiet tail
      while (words_taken < total || predicted_rsp.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #8_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/blpm_pkg.sv
rtl/core/blpm_node_store.sv
rtl/core/binary_trie_longest_prefix_match_top.sv
bench/tb.sv
